// ===== design/clock_buffer_pool_manager_unit_macros.svh =====
// Assertion macros for the buffer pool manager.
`ifndef CLOCK_BUFFER_POOL_MANAGER_UNIT_MACROS_SVH
`define CLOCK_BUFFER_POOL_MANAGER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled in reset.
`define CBPM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbpm check failed");
// Next-cycle implication, disabled in reset.
`define CBPM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbpm check failed");
`else
`define CBPM_ASSERT_IMP(label, clk, rst, ante, cons)
`define CBPM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/cbpm_pkg.sv =====
// Shared types, constants and codes of the buffer pool manager.
`timescale 1ns / 1ps
package cbpm_pkg;

  localparam int NUM_FRAMES  = 16;
  localparam int FRAME_W     = $clog2(NUM_FRAMES);
  localparam int SWEEP_MAX   = NUM_FRAMES + 2;
  localparam int CNT_W       = $clog2(SWEEP_MAX + 1);
  localparam int SCAN_W      = $clog2(NUM_FRAMES + 1);
  localparam int FRAME_OUT_W = 4;
  localparam logic [7:0] PIN_MAX = 8'hFF;

  typedef enum logic [2:0] {
    MODE_READ     = 3'd0,
    MODE_ALLOC    = 3'd1,
    MODE_UNPIN    = 3'd2,
    MODE_DISPOSE  = 3'd3,
    MODE_FLUSH    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_NOT_FOUND    = 3'd1,
    STAT_NOT_PINNED   = 3'd2,
    STAT_BUF_EXCEEDED = 3'd3,
    STAT_PAGE_PINNED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_HIT,
    OP_UNPIN,
    OP_CLEAR,
    OP_REF_CLR,
    OP_PLACE
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP,
    ST_FLUSH,
    ST_PUSH
  } ctrl_state_t;

  // Per-frame state held by one cell
  typedef struct packed {
    logic        valid;
    logic [7:0]  file;
    logic [23:0] page;
    logic [7:0]  pin;
    logic        ref_bit;
    logic        dirty;
  } frame_t;

  // Update request broadcast to the cell row
  typedef struct packed {
    cell_op_t           op;
    logic [FRAME_W-1:0] idx;
    logic               set_dirty;
    logic [7:0]         file;
    logic [23:0]        page;
  } cell_cmd_t;

  // Lookup token passed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [FRAME_W-1:0] idx;
    logic [7:0]         file;
    logic [23:0]        page;
  } tok_t;

  typedef struct packed {
    status_t                status;
    logic [FRAME_OUT_W-1:0] frame;
    logic                   fetch;
    logic                   wb_valid;
    logic [7:0]             wb_file;
    logic [23:0]            wb_page;
    logic                   last;
  } result_t;

endpackage

// ===== design/cbpm_cell.sv =====
// One frame cell: frame state plus one stage of the lookup chain.
`timescale 1ns / 1ps
module cbpm_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cbpm_pkg::FRAME_W-1:0] cell_index,
  input  cbpm_pkg::cell_cmd_t         cmd,
  input  cbpm_pkg::tok_t              tok_in,
  output cbpm_pkg::tok_t              tok_out,
  output cbpm_pkg::frame_t            frame
);
  import cbpm_pkg::*;

  logic hit_here;
  logic sel;

  // Compare this frame against the passing key
  assign hit_here = frame.valid && (frame.file == tok_in.file) && (frame.page == tok_in.page);
  assign sel      = (cmd.idx == cell_index);

  // Hand the token to the next cell, keeping the lowest match
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.found <= tok_in.found | hit_here;
    tok_out.idx   <= tok_in.found ? tok_in.idx : cell_index;
    tok_out.file  <= tok_in.file;
    tok_out.page  <= tok_in.page;
  end

  // Apply updates addressed to this frame
  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else if (sel) begin
      case (cmd.op)
        OP_HIT: begin
          if (frame.pin != PIN_MAX) frame.pin <= frame.pin + 8'd1;
          frame.ref_bit <= 1'b1;
        end
        OP_UNPIN: begin
          frame.pin   <= frame.pin - 8'd1;
          frame.dirty <= frame.dirty | cmd.set_dirty;
        end
        OP_CLEAR:   frame <= '0;
        OP_REF_CLR: frame.ref_bit <= 1'b0;
        OP_PLACE: begin
          frame.valid   <= 1'b1;
          frame.file    <= cmd.file;
          frame.page    <= cmd.page;
          frame.pin     <= 8'd1;
          frame.ref_bit <= 1'b1;
          frame.dirty   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/cbpm_ctrl.sv =====
// Request sequencer: lookup wait, clock sweep, flush scan and result issue.
`timescale 1ns / 1ps
module cbpm_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_mode,
  input  logic [7:0]                   in_file,
  input  logic [23:0]                  in_page,
  input  logic                         in_set_dirty,
  output cbpm_pkg::tok_t               tok_first,
  input  cbpm_pkg::tok_t               tok_last,
  output logic [cbpm_pkg::FRAME_W-1:0] rd_idx,
  input  cbpm_pkg::frame_t             rd_frame,
  output cbpm_pkg::cell_cmd_t          cmd,
  input  logic                         out_free,
  output logic                         push,
  output cbpm_pkg::result_t            push_res
);
  import cbpm_pkg::*;

  ctrl_state_t        state, state_next;
  mode_t              req_mode;
  logic [7:0]         req_file;
  logic [23:0]        req_page;
  logic               req_set_dirty;
  logic [FRAME_W-1:0] hand;
  logic [CNT_W-1:0]   cnt;
  logic [SCAN_W-1:0]  scan;
  logic               have_pend;
  logic [FRAME_W-1:0] pend_idx;
  logic [7:0]         pend_file;
  logic [23:0]        pend_page;
  result_t            res_q, res_d;
  logic               accept, res_load, go_sweep, go_flush, cnt_inc, scan_inc;
  logic               hand_adv, pend_load, file_match;

  function automatic logic [FRAME_W-1:0] hand_inc(input logic [FRAME_W-1:0] h);
    return (h == FRAME_W'(NUM_FRAMES - 1)) ? '0 : h + 1'b1;
  endfunction

  function automatic result_t pend_result(input status_t st, input logic lst,
                                          input logic [FRAME_W-1:0] idx,
                                          input logic [7:0] f, input logic [23:0] p);
    result_t r;
    r          = '0;
    r.status   = st;
    r.frame    = FRAME_OUT_W'(idx);
    r.wb_valid = 1'b1;
    r.wb_file  = f;
    r.wb_page  = p;
    r.last     = lst;
    return r;
  endfunction

  assign accept     = in_valid && in_ready;
  assign file_match = rd_frame.valid && (rd_frame.file == req_file);

  // Drive handshakes, cell updates and result loads per state
  always_comb begin
    in_ready  = 1'b0;
    tok_first = '0;
    rd_idx    = hand;
    cmd       = '0;
    cmd.op    = OP_NONE;
    push      = 1'b0;
    push_res  = res_q;
    res_load  = 1'b0;
    res_d     = '0;
    res_d.last = 1'b1;
    go_sweep  = 1'b0;
    go_flush  = 1'b0;
    cnt_inc   = 1'b0;
    scan_inc  = 1'b0;
    hand_adv  = 1'b0;
    pend_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_mode)
            MODE_READ, MODE_UNPIN, MODE_DISPOSE: begin
              tok_first.valid = 1'b1;
              tok_first.file  = in_file;
              tok_first.page  = in_page;
            end
            MODE_ALLOC: go_sweep = 1'b1;
            MODE_FLUSH: go_flush = 1'b1;
            default: begin
              res_load     = 1'b1;
              res_d.status = STAT_NOT_FOUND;
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        rd_idx = tok_last.idx;
        cmd.idx = tok_last.idx;
        cmd.set_dirty = req_set_dirty;
        if (tok_last.valid) begin
          case (req_mode)
            MODE_READ: begin
              if (tok_last.found) begin
                cmd.op      = OP_HIT;
                res_load    = 1'b1;
                res_d.frame = FRAME_OUT_W'(tok_last.idx);
              end else begin
                go_sweep = 1'b1;
              end
            end
            MODE_UNPIN: begin
              res_load = 1'b1;
              if (!tok_last.found) begin
                res_d.status = STAT_NOT_FOUND;
              end else if (rd_frame.pin == 8'd0) begin
                res_d.status = STAT_NOT_PINNED;
                res_d.frame  = FRAME_OUT_W'(tok_last.idx);
              end else begin
                cmd.op      = OP_UNPIN;
                res_d.frame = FRAME_OUT_W'(tok_last.idx);
              end
            end
            default: begin
              res_load = 1'b1;
              if (tok_last.found) begin
                cmd.op      = OP_CLEAR;
                res_d.frame = FRAME_OUT_W'(tok_last.idx);
              end
            end
          endcase
        end
      end
      ST_SWEEP: begin
        rd_idx   = hand;
        cmd.idx  = hand;
        cmd.file = req_file;
        cmd.page = req_page;
        if (cnt == CNT_W'(SWEEP_MAX)) begin
          res_load     = 1'b1;
          res_d.status = STAT_BUF_EXCEEDED;
        end else if (!rd_frame.valid || (!rd_frame.ref_bit && rd_frame.pin == 8'd0)) begin
          // Take this frame, reporting a dirty victim
          cmd.op         = OP_PLACE;
          res_load       = 1'b1;
          res_d.frame    = FRAME_OUT_W'(hand);
          res_d.fetch    = (req_mode == MODE_READ);
          res_d.wb_valid = rd_frame.valid && rd_frame.dirty;
          if (rd_frame.valid && rd_frame.dirty) begin
            res_d.wb_file = rd_frame.file;
            res_d.wb_page = rd_frame.page;
          end
        end else begin
          if (rd_frame.ref_bit) cmd.op = OP_REF_CLR;
          hand_adv = 1'b1;
          cnt_inc  = 1'b1;
        end
      end
      ST_FLUSH: begin
        rd_idx  = scan[FRAME_W-1:0];
        cmd.idx = scan[FRAME_W-1:0];
        if (scan == SCAN_W'(NUM_FRAMES)) begin
          res_load = 1'b1;
          if (have_pend) res_d = pend_result(STAT_OK, 1'b1, pend_idx, pend_file, pend_page);
        end else if (file_match && rd_frame.pin != 8'd0) begin
          // Stop at the first pinned frame of the file
          res_load = 1'b1;
          if (have_pend) begin
            res_d = pend_result(STAT_PAGE_PINNED, 1'b1, pend_idx, pend_file, pend_page);
          end else begin
            res_d.status = STAT_PAGE_PINNED;
            res_d.frame  = FRAME_OUT_W'(scan[FRAME_W-1:0]);
          end
        end else if (file_match && rd_frame.dirty) begin
          // Hold one write-back back so the last one can carry the status
          if (!have_pend || out_free) begin
            push      = have_pend;
            push_res  = pend_result(STAT_OK, 1'b0, pend_idx, pend_file, pend_page);
            pend_load = 1'b1;
            cmd.op    = OP_CLEAR;
            scan_inc  = 1'b1;
          end
        end else begin
          if (file_match) cmd.op = OP_CLEAR;
          scan_inc = 1'b1;
        end
      end
      ST_PUSH: begin
        push = out_free;
      end
      default: ;
    endcase
  end

  // Select the next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (go_sweep)            state_next = ST_SWEEP;
          else if (go_flush)       state_next = ST_FLUSH;
          else if (res_load)       state_next = ST_PUSH;
          else                     state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (go_sweep)      state_next = ST_SWEEP;
        else if (res_load) state_next = ST_PUSH;
      end
      ST_SWEEP, ST_FLUSH: begin
        if (res_load) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (push) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hand      <= FRAME_W'(NUM_FRAMES - 1);
      cnt       <= '0;
      scan      <= '0;
      have_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (go_sweep || hand_adv) hand <= hand_inc(hand);
      if (go_sweep) cnt <= '0;
      else if (cnt_inc) cnt <= cnt + 1'b1;
      if (go_flush) begin
        scan      <= '0;
        have_pend <= 1'b0;
      end else begin
        if (scan_inc) scan <= scan + 1'b1;
        if (pend_load) have_pend <= 1'b1;
      end
    end
  end

  // Request, pending write-back and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode      <= mode_t'(in_mode);
      req_file      <= in_file;
      req_page      <= in_page;
      req_set_dirty <= in_set_dirty;
    end
    if (pend_load) begin
      pend_idx  <= scan[FRAME_W-1:0];
      pend_file <= rd_frame.file;
      pend_page <= rd_frame.page;
    end
    if (res_load) res_q <= res_d;
  end

endmodule

// ===== design/clock_buffer_pool_manager_unit.sv =====
// Top level of the buffer pool manager: cell row, sequencer and output register.
//
// Input stream (s_axis_*): one request per item: mode, file, page, dirty mark.
// Output stream (m_axis_*): one result per request, or one per written-back
// frame on a flush; tlast marks the final result of a request.
// A request is taken only while the sequencer is idle. Per request:
//   unpin, dispose, read hit: the lookup token walks the cell row one frame
//     per cycle;
//   allocate: the clock sweep visits one frame per cycle; a read miss walks
//     the cell row first and then runs the sweep;
//   flush: a scan over every frame, plus any stall on the output.
// The final result sits in the output register, so the next request is taken
// while it waits. A stalled receiver holds a flush mid-scan when a second
// write-back is ready; nothing is dropped.
// Reset (rst, synchronous) empties every frame and sets the clock hand to the
// last frame; the block takes requests on the next cycle.
`timescale 1ns / 1ps
`include "clock_buffer_pool_manager_unit_macros.svh"
module clock_buffer_pool_manager_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // mode[2:0], file_id[10:3], page_number[34:11], set_dirty[35]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // status[2:0], frame_index[6:3], fetch_needed[7],
                                     // writeback_valid[8], writeback_file[16:9],
                                     // writeback_page[40:17]
  output logic        m_axis_tlast
);
  import cbpm_pkg::*;

  tok_t               tok [NUM_FRAMES+1];
  frame_t             frames [NUM_FRAMES];
  cell_cmd_t          cmd;
  logic [FRAME_W-1:0] rd_idx;
  logic               out_free, push;
  result_t            push_res, out_res;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  cbpm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_mode      (s_axis_tdata[2:0]),
    .in_file      (s_axis_tdata[10:3]),
    .in_page      (s_axis_tdata[34:11]),
    .in_set_dirty (s_axis_tdata[35]),
    .tok_first    (tok[0]),
    .tok_last     (tok[NUM_FRAMES]),
    .rd_idx       (rd_idx),
    .rd_frame     (frames[rd_idx]),
    .cmd          (cmd),
    .out_free     (out_free),
    .push         (push),
    .push_res     (push_res)
  );

  // Row of frame cells
  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    cbpm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (FRAME_W'(i)),
      .cmd        (cmd),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1]),
      .frame      (frames[i])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) out_res <= push_res;
  end

  assign m_axis_tdata = {7'd0, out_res.wb_page, out_res.wb_file, out_res.wb_valid,
                         out_res.fetch, out_res.frame, out_res.status};
  assign m_axis_tlast = out_res.last;

  // A request leaves the sequencer busy on the next cycle
  `CBPM_ASSERT_NXT(a_busy_after_req, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A lookup token only completes while a request is in work
  `CBPM_ASSERT_IMP(a_tok_busy, clk, rst, tok[NUM_FRAMES].valid, !s_axis_tready)
  // Write-backs carry only ok or page-pinned status
  `CBPM_ASSERT_IMP(a_wb_status, clk, rst, m_axis_tvalid && m_axis_tdata[8],
                   m_axis_tdata[2:0] == STAT_OK || m_axis_tdata[2:0] == STAT_PAGE_PINNED)

endmodule
